[src/rbvt_pkg.sv]
// ----------------------------------------------------------------------------
// rbvt_pkg
// Shared types and constants for the row bank valid tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rbvt_pkg;

  localparam int BANK_COUNT = 8;
  localparam int CFG_W      = 11;
  localparam int MODE_W     = 2;
  localparam int CIDX_W     = 2;
  localparam int TIME_W     = 32;

  // Request modes; the fourth code means nothing and falls to a default arm
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAN = 2'd2;

  // Config register indexes
  localparam logic [CIDX_W-1:0] REG_TRIGGER = 2'd0;
  localparam logic [CIDX_W-1:0] REG_KEEP    = 2'd1;

  localparam logic [CFG_W-1:0] TRIGGER_RESET = 11'd819;
  localparam logic [CFG_W-1:0] KEEP_RESET    = 11'd512;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_INSERT,
    ST_EVICT,
    ST_DONE
  } state_t;

  // Number of set bits in a bank mask
  function automatic logic [3:0] popcount8(input logic [BANK_COUNT-1:0] m);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < BANK_COUNT; i++) begin
      n = n + {3'd0, m[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[src/rbvt_cell.sv]
// ----------------------------------------------------------------------------
// rbvt_cell
// One table entry of the ring; takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvt_cell
  import rbvt_pkg::*;
#(
  parameter int RW = 16
) (
  input  wire logic                  clk,
  input  wire logic                  shift,
  input  wire logic                  d_vld,
  input  wire logic [RW-1:0]         d_row,
  input  wire logic [BANK_COUNT-1:0] d_mask,
  input  wire logic                  d_par,
  input  wire logic [TIME_W-1:0]     d_time,
  output logic                       q_vld,
  output logic [RW-1:0]              q_row,
  output logic [BANK_COUNT-1:0]      q_mask,
  output logic                       q_par,
  output logic [TIME_W-1:0]          q_time
);

  // Entry register; cleared by the controller's clearing pass, not by reset
  always_ff @(posedge clk) begin
    if (shift) begin
      q_vld  <= d_vld;
      q_row  <= d_row;
      q_mask <= d_mask;
      q_par  <= d_par;
      q_time <= d_time;
    end
  end

endmodule

`default_nettype wire

[src/rbvt_ctrl.sv]
// ----------------------------------------------------------------------------
// rbvt_ctrl
// Sequencer at the head of the ring: lookup, insert, eviction, result.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvt_ctrl
  import rbvt_pkg::*;
#(
  parameter int N  = 1024,
  parameter int RW = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [15:0]           row,
  input  wire logic [2:0]            bank,
  input  wire logic [TIME_W-1:0]     timestamp,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       answer,
  output logic                       overflow,
  output logic [CFG_W-1:0]           entries_in_use,
  input  wire logic                  cfg_we,
  input  wire logic [CIDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic                       shift,
  input  wire logic                  h_vld,
  input  wire logic [RW-1:0]         h_row,
  input  wire logic [BANK_COUNT-1:0] h_mask,
  input  wire logic                  h_par,
  input  wire logic [TIME_W-1:0]     h_time,
  output logic                       t_vld,
  output logic [RW-1:0]              t_row,
  output logic [BANK_COUNT-1:0]      t_mask,
  output logic                       t_par,
  output logic [TIME_W-1:0]          t_time
);

  localparam int CW   = $clog2(N);
  localparam int UW   = $clog2(N + 1);
  localparam int CMPW = (UW > CFG_W) ? UW : CFG_W;
  localparam int KW   = TIME_W + RW;
  localparam logic [CW-1:0] LAST = CW'(N - 1);

  state_t                  state, state_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic [UW-1:0]           used, used_next;
  logic [MODE_W-1:0]       mode_r, mode_r_next;
  logic [RW-1:0]           row_r, row_r_next;
  logic [BANK_COUNT-1:0]   bit_r, bit_r_next;
  logic [TIME_W-1:0]       ts_r, ts_r_next;
  logic                    found, found_next;
  logic                    ans, ans_next;
  logic                    ovf, ovf_next;
  logic                    best_vld, best_vld_next;
  logic [KW-1:0]           best_key, best_key_next;
  logic                    evict_vld, evict_vld_next;
  logic [KW-1:0]           evict_key, evict_key_next;
  logic [CFG_W-1:0]        trigger_count, keep_count;
  logic                    out_valid_next, answer_next, overflow_next;
  logic [CFG_W-1:0]        entries_in_use_next;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_count <= TRIGGER_RESET;
      keep_count    <= KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER: trigger_count <= cfg_data;
        REG_KEEP:    keep_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      used      <= used_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r         <= mode_r_next;
    row_r          <= row_r_next;
    bit_r          <= bit_r_next;
    ts_r           <= ts_r_next;
    found          <= found_next;
    ans            <= ans_next;
    ovf            <= ovf_next;
    best_vld       <= best_vld_next;
    best_key       <= best_key_next;
    evict_vld      <= evict_vld_next;
    evict_key      <= evict_key_next;
    answer         <= answer_next;
    overflow       <= overflow_next;
    entries_in_use <= entries_in_use_next;
  end

  // Next state, head update and result
  always_comb begin
    logic [BANK_COUNT-1:0] m;
    logic [KW-1:0]         hkey;
    logic                  hit;

    state_next          = state;
    cnt_next            = cnt;
    used_next           = used;
    mode_r_next         = mode_r;
    row_r_next          = row_r;
    bit_r_next          = bit_r;
    ts_r_next           = ts_r;
    found_next          = found;
    ans_next            = ans;
    ovf_next            = ovf;
    best_vld_next       = best_vld;
    best_key_next       = best_key;
    evict_vld_next      = evict_vld;
    evict_key_next      = evict_key;
    answer_next         = answer;
    overflow_next       = overflow;
    entries_in_use_next = entries_in_use;
    out_valid_next      = out_valid && out_stall;
    in_stall            = (state != ST_IDLE);
    shift               = 1'b0;
    t_vld               = h_vld;
    t_row               = h_row;
    t_mask              = h_mask;
    t_par               = h_par;
    t_time              = h_time;
    m                   = h_mask | bit_r;
    hkey                = {h_time, h_row};
    hit                 = h_vld && (h_row == row_r);

    case (state)
      ST_CLEAR: begin
        shift    = 1'b1;
        t_vld    = 1'b0;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_r_next    = mode;
          row_r_next     = RW'(row);
          bit_r_next     = BANK_COUNT'(1) << bank;
          ts_r_next      = timestamp;
          ans_next       = 1'b0;
          ovf_next       = 1'b0;
          found_next     = 1'b0;
          best_vld_next  = 1'b0;
          evict_vld_next = 1'b0;
          cnt_next       = '0;
          case (mode)
            MODE_READ, MODE_WRITE: state_next = ST_SEARCH;
            MODE_CLEAN: begin
              if (CMPW'(used) > CMPW'(trigger_count)) begin
                ans_next   = 1'b1;
                state_next = (CMPW'(used) > CMPW'(keep_count)) ? ST_EVICT : ST_DONE;
              end else begin
                state_next = ST_DONE;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SEARCH: begin
        shift    = 1'b1;
        cnt_next = cnt + 1'b1;
        // rows are unique, so at most one entry matches
        if (hit) begin
          found_next = 1'b1;
          t_time     = ts_r;
          if (mode_r == MODE_READ) begin
            if ((h_mask & bit_r) != '0) begin
              ans_next = 1'b1;
            end else if (popcount8(h_mask) <= 4'd2) begin
              t_mask   = m;
              t_par    = 1'b1;
              ans_next = 1'b0;
            end else begin
              t_mask   = m;
              ans_next = h_par;
            end
          end else begin
            t_mask   = m;
            t_par    = (popcount8(m) >= 4'd4);
            ans_next = (m != '1);
          end
        end
        if (cnt == LAST) begin
          if (found || hit) begin
            state_next = ST_DONE;
          end else if (used == UW'(N)) begin
            ovf_next   = 1'b1;
            ans_next   = 1'b0;
            state_next = ST_DONE;
          end else begin
            state_next = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        shift = 1'b1;
        if (!h_vld) begin
          t_vld      = 1'b1;
          t_row      = row_r;
          t_mask     = bit_r;
          t_par      = 1'b0;
          t_time     = ts_r;
          used_next  = used + 1'b1;
          ans_next   = (mode_r == MODE_WRITE);
          state_next = ST_DONE;
        end
      end
      ST_EVICT: begin
        shift    = 1'b1;
        cnt_next = cnt + 1'b1;
        // drop last pass's oldest, track the oldest of the rest
        if (evict_vld && h_vld && (hkey == evict_key)) begin
          t_vld     = 1'b0;
          used_next = used - 1'b1;
        end else if (h_vld && (!best_vld || (hkey < best_key))) begin
          best_vld_next = 1'b1;
          best_key_next = hkey;
        end
        if (cnt == LAST) begin
          if (best_vld_next && (CMPW'(used_next) > CMPW'(keep_count))) begin
            evict_vld_next = 1'b1;
            evict_key_next = best_key_next;
            best_vld_next  = 1'b0;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next      = 1'b1;
          answer_next         = ans;
          overflow_next       = ovf;
          entries_in_use_next = CFG_W'(used);
          state_next          = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/row_bank_valid_tracker_top.sv]
// ----------------------------------------------------------------------------
// row_bank_valid_tracker_top
// Row table held in a ring of entry cells that rotates past one controller.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   input     in_valid / in_stall    mode, row, bank, timestamp
//   output    out_valid / out_stall  answer, overflow, entries_in_use
//   config    cfg_we                 cfg_index, cfg_data
//
// Read or write: a lookup over every entry as the ring turns; an insert
// then turns it on to a free cell. Cleanup that evicts drops, on each
// revolution, the oldest entry found on the one before until used <= keep_count.
// The ring passes one entry a cycle to the controller while it shifts;
// that sets the rate. A clearing pass after reset holds in_stall high.
// One request in flight; a finished result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module row_bank_valid_tracker_top
  import rbvt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int ROW_BITS      = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [15:0]       row,
  input  wire logic [2:0]        bank,
  input  wire logic [TIME_W-1:0] timestamp,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   answer,
  output logic                   overflow,
  output logic [CFG_W-1:0]       entries_in_use,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic                  shift;
  logic                  t_vld, t_par;
  logic [ROW_BITS-1:0]   t_row;
  logic [BANK_COUNT-1:0] t_mask;
  logic [TIME_W-1:0]     t_time;

  logic                  c_vld  [TABLE_ENTRIES];
  logic [ROW_BITS-1:0]   c_row  [TABLE_ENTRIES];
  logic [BANK_COUNT-1:0] c_mask [TABLE_ENTRIES];
  logic                  c_par  [TABLE_ENTRIES];
  logic [TIME_W-1:0]     c_time [TABLE_ENTRIES];

  rbvt_ctrl #(.N(TABLE_ENTRIES), .RW(ROW_BITS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .mode, .row, .bank, .timestamp,
    .out_valid, .out_stall, .answer, .overflow, .entries_in_use,
    .cfg_we, .cfg_index, .cfg_data, .shift,
    .h_vld  (c_vld[TABLE_ENTRIES-1]),
    .h_row  (c_row[TABLE_ENTRIES-1]),
    .h_mask (c_mask[TABLE_ENTRIES-1]),
    .h_par  (c_par[TABLE_ENTRIES-1]),
    .h_time (c_time[TABLE_ENTRIES-1]),
    .t_vld, .t_row, .t_mask, .t_par, .t_time
  );

  // Ring of cells: cell 0 takes the controller's updated head entry
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      rbvt_cell #(.RW(ROW_BITS)) u_cell (
        .clk, .shift,
        .d_vld (t_vld), .d_row (t_row), .d_mask (t_mask), .d_par (t_par),
        .d_time (t_time),
        .q_vld (c_vld[i]), .q_row (c_row[i]), .q_mask (c_mask[i]),
        .q_par (c_par[i]), .q_time (c_time[i])
      );
    end else begin : g_next
      rbvt_cell #(.RW(ROW_BITS)) u_cell (
        .clk, .shift,
        .d_vld (c_vld[i-1]), .d_row (c_row[i-1]), .d_mask (c_mask[i-1]),
        .d_par (c_par[i-1]), .d_time (c_time[i-1]),
        .q_vld (c_vld[i]), .q_row (c_row[i]), .q_mask (c_mask[i]),
        .q_par (c_par[i]), .q_time (c_time[i])
      );
    end
  end

endmodule

`default_nettype wire

[src/rbvt_checker.sv]
// ----------------------------------------------------------------------------
// rbvt_checker
// Port-level checks of the row bank valid tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbvt_checker
  import rbvt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [MODE_W-1:0] mode,
  input wire logic [15:0]       row,
  input wire logic [2:0]        bank,
  input wire logic [TIME_W-1:0] timestamp,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              answer,
  input wire logic              overflow,
  input wire logic [CFG_W-1:0]  entries_in_use,
  input wire logic              cfg_we,
  input wire logic [CIDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0]  cfg_data
);

  // clearing pass blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request taken during clearing pass");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(answer) &&
    $stable(overflow) && $stable(entries_in_use)))
    else $error("stalled result changed");

  // a dropped insert is never served nor writeback-free
  a_overflow_answer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> !answer)
    else $error("overflow with answer set");

endmodule

bind row_bank_valid_tracker_top rbvt_checker u_rbvt_checker (.*);

`default_nettype wire
